>>> hw/rtl/node_to_extended_center_average_core_assert.svh
// Assertion macros shared by the node-to-extended-center averager RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef NODE_TO_EXTENDED_CENTER_AVERAGE_CORE_ASSERT_SVH
`define NODE_TO_EXTENDED_CENTER_AVERAGE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication under an active-low reset
`define NTEC_ASSERT_IMPL(label, clock, resetn, pre, post) \
    label: assert property (@(posedge clock) disable iff (!resetn) (pre) |-> (post)) \
        else $error("ntec: same-cycle check failed");
// Next-cycle implication under an active-low reset
`define NTEC_ASSERT_NEXT(label, clock, resetn, pre, post) \
    label: assert property (@(posedge clock) disable iff (!resetn) (pre) |=> (post)) \
        else $error("ntec: next-cycle check failed");
`else
`define NTEC_ASSERT_IMPL(label, clock, resetn, pre, post)
`define NTEC_ASSERT_NEXT(label, clock, resetn, pre, post)
`endif
`endif

>>> hw/rtl/ntec_pkg.sv
// Shared constants, types and register codes of the extended-center averager.
// No dependencies; the core, fetch, sum and emit files refer to it by scoped names.
package ntec_pkg;

    // Grid limits and sample width
    localparam int MAX_I       = 64;
    localparam int MAX_J       = 64;
    localparam int MAX_K       = 64;
    localparam int VALUE_WIDTH = 32;

    // Count registers and output coordinates are 7 bits wide
    localparam int CNT_W       = 7;
    localparam int RESET_COUNT = 64;

    localparam int POS_I_W     = $clog2(MAX_I);
    localparam int POS_J_W     = $clog2(MAX_J);
    localparam int POS_K_W     = $clog2(MAX_K);
    localparam int ADDR_W      = POS_I_W + POS_J_W;
    localparam int PLANE_DEPTH = 1 << ADDR_W;

    // Growth of the partial sums through the adder pipeline
    localparam int PAIR_W = VALUE_WIDTH + 1;
    localparam int QUAD_W = VALUE_WIDTH + 2;
    localparam int OCT_W  = VALUE_WIDTH + 3;

    // Number of candidate averages per node (lower-neighbor choice per axis)
    localparam int NUM_AVG = 8;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_I = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_J = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_K = 2'd2;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [CNT_W-1:0]              count_t;

    // Position of a node and whether it is the last along each axis
    typedef struct packed {
        logic [POS_I_W-1:0] pos_i;
        logic [POS_J_W-1:0] pos_j;
        logic [POS_K_W-1:0] pos_k;
        logic               last_i;
        logic               last_j;
        logic               last_k;
    } node_meta_t;

    // The eight nodes around a node: west is i-1, north is j-1, back is k-1
    typedef struct packed {
        value_t cur;
        value_t west;
        value_t north;
        value_t north_west;
        value_t back;
        value_t back_west;
        value_t back_north;
        value_t back_north_west;
    } nbr_set_t;

endpackage

>>> hw/rtl/node_to_extended_center_average_core.sv
// Top level of the node-to-extended-center averager: count registers and the
// fetch, adder and emit stages. Depends on ntec_pkg, ntec_fetch, ntec_sum, ntec_emit.
//
//  channel   | handshake              | payload
//  ----------+------------------------+------------------------------------------
//  node in   | in_valid / in_ready    | node_value
//  result    | out_valid / out_ready  | ext_i, ext_j, ext_k, center_value,
//            |                        | last_of_run, volume_done
//  config    | cfg_write              | cfg_index, cfg_data
//
// An input transaction reaches its first result through the row/plane memory read,
// three adder stages and the output register.
// One node per cycle when it yields one result and out_ready holds; a border node
// yields 2, 4 or 8 results and holds the input back while the single output register
// takes them, one result per cycle when out_ready is high.
// Reset clears control state and sets all counts to 64; the plane memories need
// no clearing pass. A count write restarts the volume at node (0,0,0).
module node_to_extended_center_average_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [ntec_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ntec_pkg::CNT_W-1:0]         cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [ntec_pkg::VALUE_WIDTH-1:0] node_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [ntec_pkg::CNT_W-1:0]         ext_i,
    output logic [ntec_pkg::CNT_W-1:0]         ext_j,
    output logic [ntec_pkg::CNT_W-1:0]         ext_k,
    output logic signed [ntec_pkg::VALUE_WIDTH-1:0] center_value,
    output logic                               last_of_run,
    output logic                               volume_done
);

    localparam ntec_pkg::count_t LIMIT_I = ntec_pkg::CNT_W'(ntec_pkg::MAX_I);
    localparam ntec_pkg::count_t LIMIT_J = ntec_pkg::CNT_W'(ntec_pkg::MAX_J);
    localparam ntec_pkg::count_t LIMIT_K = ntec_pkg::CNT_W'(ntec_pkg::MAX_K);
    localparam ntec_pkg::count_t RST_CNT = ntec_pkg::CNT_W'(ntec_pkg::RESET_COUNT);
    localparam ntec_pkg::count_t ONE     = ntec_pkg::CNT_W'(1);

    ntec_pkg::count_t  cnt_i_reg;
    ntec_pkg::count_t  cnt_j_reg;
    ntec_pkg::count_t  cnt_k_reg;
    ntec_pkg::count_t  clamp_i;
    ntec_pkg::count_t  clamp_j;
    ntec_pkg::count_t  clamp_k;
    logic              restart;

    logic                  nbr_valid;
    logic                  nbr_ready;
    ntec_pkg::nbr_set_t    nbr;
    ntec_pkg::node_meta_t  nbr_meta;
    logic                  sum_valid;
    logic                  sum_take;
    ntec_pkg::value_t      sum_avg [ntec_pkg::NUM_AVG];
    ntec_pkg::node_meta_t  sum_meta;

    // Clamp a written count into one to the axis maximum
    always_comb
    begin
        clamp_i = (cfg_data == '0) ? ONE : ((cfg_data > LIMIT_I) ? LIMIT_I : cfg_data);
        clamp_j = (cfg_data == '0) ? ONE : ((cfg_data > LIMIT_J) ? LIMIT_J : cfg_data);
        clamp_k = (cfg_data == '0) ? ONE : ((cfg_data > LIMIT_K) ? LIMIT_K : cfg_data);
    end

    assign restart = cfg_write && ((cfg_index == ntec_pkg::REG_COUNT_I)
                                || (cfg_index == ntec_pkg::REG_COUNT_J)
                                || (cfg_index == ntec_pkg::REG_COUNT_K));

    // Count registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_i_reg <= (RST_CNT > LIMIT_I) ? LIMIT_I : RST_CNT;
            cnt_j_reg <= (RST_CNT > LIMIT_J) ? LIMIT_J : RST_CNT;
            cnt_k_reg <= (RST_CNT > LIMIT_K) ? LIMIT_K : RST_CNT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ntec_pkg::REG_COUNT_I: cnt_i_reg <= clamp_i;
                ntec_pkg::REG_COUNT_J: cnt_j_reg <= clamp_j;
                ntec_pkg::REG_COUNT_K: cnt_k_reg <= clamp_k;
                default:
                begin
                    cnt_i_reg <= cnt_i_reg;
                end
            endcase
        end
    end

    ntec_fetch u_fetch (
        .clk        (clk),
        .rst_n      (rst_n),
        .cnt_i      (cnt_i_reg),
        .cnt_j      (cnt_j_reg),
        .cnt_k      (cnt_k_reg),
        .restart    (restart),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .node_value (node_value),
        .nbr_valid  (nbr_valid),
        .nbr_ready  (nbr_ready),
        .nbr        (nbr),
        .nbr_meta   (nbr_meta)
    );

    ntec_sum u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (nbr_valid),
        .in_ready  (nbr_ready),
        .nbr       (nbr),
        .nbr_meta  (nbr_meta),
        .sum_valid (sum_valid),
        .sum_take  (sum_take),
        .avg       (sum_avg),
        .sum_meta  (sum_meta)
    );

    ntec_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .sum_valid    (sum_valid),
        .sum_take     (sum_take),
        .avg          (sum_avg),
        .sum_meta     (sum_meta),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .ext_i        (ext_i),
        .ext_j        (ext_j),
        .ext_k        (ext_k),
        .center_value (center_value),
        .last_of_run  (last_of_run),
        .volume_done  (volume_done)
    );

endmodule

>>> hw/rtl/ntec_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Read-first: a read of the address written in the same cycle returns old data.
module ntec_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/ntec_fetch.sv
// Node position tracking, plane memories and neighbor gathering.
// Depends on ntec_pkg, ntec_ram and the assertion macro header.
`include "node_to_extended_center_average_core_assert.svh"

module ntec_fetch (
    input  logic                clk,
    input  logic                rst_n,
    input  ntec_pkg::count_t    cnt_i,
    input  ntec_pkg::count_t    cnt_j,
    input  ntec_pkg::count_t    cnt_k,
    input  logic                restart,
    input  logic                in_valid,
    output logic                in_ready,
    input  ntec_pkg::value_t    node_value,
    output logic                nbr_valid,
    input  logic                nbr_ready,
    output ntec_pkg::nbr_set_t  nbr,
    output ntec_pkg::node_meta_t nbr_meta
);

    localparam int VW = ntec_pkg::VALUE_WIDTH;

    logic [ntec_pkg::POS_I_W-1:0] pos_i_reg;
    logic [ntec_pkg::POS_J_W-1:0] pos_j_reg;
    logic [ntec_pkg::POS_K_W-1:0] pos_k_reg;

    ntec_pkg::node_meta_t          a_meta;
    logic                          accept;
    logic                          b_go;
    logic [ntec_pkg::ADDR_W-1:0]   q_addr;
    logic [ntec_pkg::ADDR_W-1:0]   p_rd_addr;
    logic [VW-1:0]                 q_rd_data;
    logic [2*VW-1:0]               p_rd_data;
    logic [2*VW-1:0]               p_wr_data;
    logic [2*VW-1:0]               p_word;

    logic                          b_valid_reg;
    ntec_pkg::value_t              b_value_reg;
    ntec_pkg::node_meta_t          b_meta_reg;
    logic [ntec_pkg::ADDR_W-1:0]   b_addr_reg;
    logic                          fwd_reg;
    logic [2*VW-1:0]               fwd_data_reg;

    ntec_pkg::value_t              prev_cur_reg;
    ntec_pkg::value_t              prev_north_reg;
    ntec_pkg::value_t              prev_back_reg;
    ntec_pkg::value_t              prev_back_north_reg;

    ntec_pkg::value_t              north;
    ntec_pkg::value_t              back;
    ntec_pkg::value_t              back_north;

    // Flag the node that ends each axis
    always_comb
    begin
        a_meta.pos_i  = pos_i_reg;
        a_meta.pos_j  = pos_j_reg;
        a_meta.pos_k  = pos_k_reg;
        a_meta.last_i = (ntec_pkg::CNT_W'(pos_i_reg) == cnt_i - ntec_pkg::CNT_W'(1));
        a_meta.last_j = (ntec_pkg::CNT_W'(pos_j_reg) == cnt_j - ntec_pkg::CNT_W'(1));
        a_meta.last_k = (ntec_pkg::CNT_W'(pos_k_reg) == cnt_k - ntec_pkg::CNT_W'(1));
    end

    assign in_ready = !b_valid_reg || nbr_ready;
    assign accept   = in_valid && in_ready;
    assign b_go     = b_valid_reg && nbr_ready;

    // Advance the raster position on each input transaction; restart returns it to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_i_reg <= '0;
            pos_j_reg <= '0;
            pos_k_reg <= '0;
        end
        else if (restart)
        begin
            pos_i_reg <= '0;
            pos_j_reg <= '0;
            pos_k_reg <= '0;
        end
        else if (accept)
        begin
            if (a_meta.last_i)
            begin
                pos_i_reg <= '0;
                if (a_meta.last_j)
                begin
                    pos_j_reg <= '0;
                    pos_k_reg <= a_meta.last_k ? '0 : pos_k_reg + 1'b1;
                end
                else
                begin
                    pos_j_reg <= pos_j_reg + 1'b1;
                end
            end
            else
            begin
                pos_i_reg <= pos_i_reg + 1'b1;
            end
        end
    end

    // Same node in the previous plane, and the node one row up
    assign q_addr    = {pos_j_reg, pos_i_reg};
    assign p_rd_addr = {ntec_pkg::POS_J_W'(pos_j_reg - 1'b1), pos_i_reg};

    // Latest plane: read the old value (previous plane) while writing the new one
    ntec_ram #(
        .WIDTH (VW),
        .DEPTH (ntec_pkg::PLANE_DEPTH)
    ) u_plane_ram (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (q_addr),
        .wr_data (node_value),
        .rd_en   (accept),
        .rd_addr (q_addr),
        .rd_data (q_rd_data)
    );

    // Row store: each entry holds the node and the node behind it
    assign p_wr_data = {b_value_reg, q_rd_data};

    ntec_ram #(
        .WIDTH (2 * VW),
        .DEPTH (ntec_pkg::PLANE_DEPTH)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (b_go),
        .wr_addr (b_addr_reg),
        .wr_data (p_wr_data),
        .rd_en   (accept),
        .rd_addr (p_rd_addr),
        .rd_data (p_rd_data)
    );

    // Stage B control: hold while downstream stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                b_valid_reg <= in_valid;
            end
            if (accept)
            begin
                fwd_reg <= b_go && (b_addr_reg == p_rd_addr);
            end
        end
    end

    // Stage B payload; capture a row write that collides with the row read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_value_reg  <= node_value;
            b_meta_reg   <= a_meta;
            b_addr_reg   <= q_addr;
            fwd_data_reg <= p_wr_data;
        end
    end

    assign p_word     = fwd_reg ? fwd_data_reg : p_rd_data;
    assign north      = p_word[2*VW-1:VW];
    assign back_north = p_word[VW-1:0];
    assign back       = q_rd_data;

    // Keep this node's column for the next node along i
    always_ff @(posedge clk)
    begin
        if (b_go)
        begin
            prev_cur_reg        <= b_value_reg;
            prev_north_reg      <= north;
            prev_back_reg       <= back;
            prev_back_north_reg <= back_north;
        end
    end

    always_comb
    begin
        nbr.cur             = b_value_reg;
        nbr.west            = prev_cur_reg;
        nbr.north           = north;
        nbr.north_west      = prev_north_reg;
        nbr.back            = back;
        nbr.back_west       = prev_back_reg;
        nbr.back_north      = back_north;
        nbr.back_north_west = prev_back_north_reg;
    end

    assign nbr_valid = b_valid_reg;
    assign nbr_meta  = b_meta_reg;

    `NTEC_ASSERT_NEXT(a_b_stall_holds, clk, rst_n, b_valid_reg && !nbr_ready,
        b_valid_reg && $stable(b_addr_reg))
    `NTEC_ASSERT_IMPL(a_fwd_single_column, clk, rst_n, fwd_reg && b_valid_reg,
        b_meta_reg.pos_i == '0)

endmodule

>>> hw/rtl/ntec_sum.sv
// Three-stage adder pipeline: i pairs, then j pairs, then k pairs and divide by 8.
// Produces all eight lower-neighbor choices of a node. Depends on ntec_pkg.
module ntec_sum (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ntec_pkg::nbr_set_t    nbr,
    input  ntec_pkg::node_meta_t  nbr_meta,
    output logic                  sum_valid,
    input  logic                  sum_take,
    output ntec_pkg::value_t      avg [ntec_pkg::NUM_AVG],
    output ntec_pkg::node_meta_t  sum_meta
);

    localparam int PW = ntec_pkg::PAIR_W;
    localparam int QW = ntec_pkg::QUAD_W;
    localparam int OW = ntec_pkg::OCT_W;
    localparam int VW = ntec_pkg::VALUE_WIDTH;

    logic ready1;
    logic ready2;
    logic ready3;

    logic                  s1_valid_reg;
    logic                  s2_valid_reg;
    logic                  s3_valid_reg;
    ntec_pkg::node_meta_t  s1_meta_reg;
    ntec_pkg::node_meta_t  s2_meta_reg;
    ntec_pkg::node_meta_t  s3_meta_reg;

    // Index {back, north}
    logic signed [PW-1:0]  s1_pair_reg [4];
    ntec_pkg::value_t      s1_self_reg [4];
    logic signed [PW-1:0]  pair_next   [4];
    ntec_pkg::value_t      self_next   [4];

    // Index {back, uses_north, uses_west}
    logic signed [PW-1:0]  pi_one  [4];
    logic signed [PW-1:0]  pi_zero [4];
    logic signed [QW-1:0]  s2_pj_reg [8];
    logic signed [QW-1:0]  pj_next   [8];

    // Index {uses_back, uses_north, uses_west}
    logic signed [OW-1:0]  tot       [8];
    ntec_pkg::value_t      s3_avg_reg [8];

    assign ready3   = !s3_valid_reg || sum_take;
    assign ready2   = !s2_valid_reg || ready3;
    assign ready1   = !s1_valid_reg || ready2;
    assign in_ready = ready1;

    // Pair each node with its west neighbor
    always_comb
    begin
        self_next[0] = nbr.cur;
        self_next[1] = nbr.north;
        self_next[2] = nbr.back;
        self_next[3] = nbr.back_north;
        pair_next[0] = PW'(nbr.cur)        + PW'(nbr.west);
        pair_next[1] = PW'(nbr.north)      + PW'(nbr.north_west);
        pair_next[2] = PW'(nbr.back)       + PW'(nbr.back_west);
        pair_next[3] = PW'(nbr.back_north) + PW'(nbr.back_north_west);
    end

    // Combine rows: with or without the north row
    always_comb
    begin
        for (int n = 0; n < 4; n++)
        begin
            pi_one[n]  = s1_pair_reg[n];
            pi_zero[n] = {s1_self_reg[n], 1'b0};
        end
        for (int b = 0; b < 2; b++)
        begin
            for (int w = 0; w < 2; w++)
            begin
                pj_next[4*b + 2 + w] = QW'((w != 0) ? pi_one[2*b + 1] : pi_zero[2*b + 1])
                                     + QW'((w != 0) ? pi_one[2*b] : pi_zero[2*b]);
                pj_next[4*b + w]     = {((w != 0) ? pi_one[2*b] : pi_zero[2*b]), 1'b0};
            end
        end
    end

    // Combine planes; the stage-three register keeps the floor of the eighth
    always_comb
    begin
        for (int n = 0; n < 4; n++)
        begin
            tot[4 + n] = OW'(s2_pj_reg[4 + n]) + OW'(s2_pj_reg[n]);
            tot[n]     = {s2_pj_reg[n], 1'b0};
        end
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (ready2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ready3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (ready1 && in_valid)
        begin
            s1_meta_reg <= nbr_meta;
            for (int n = 0; n < 4; n++)
            begin
                s1_pair_reg[n] <= pair_next[n];
                s1_self_reg[n] <= self_next[n];
            end
        end
        if (ready2 && s1_valid_reg)
        begin
            s2_meta_reg <= s1_meta_reg;
            for (int n = 0; n < 8; n++)
            begin
                s2_pj_reg[n] <= pj_next[n];
            end
        end
        if (ready3 && s2_valid_reg)
        begin
            s3_meta_reg <= s2_meta_reg;
            for (int n = 0; n < 8; n++)
            begin
                s3_avg_reg[n] <= tot[n][OW-1:OW-VW];
            end
        end
    end

    assign sum_valid = s3_valid_reg;
    assign sum_meta  = s3_meta_reg;

    always_comb
    begin
        for (int n = 0; n < ntec_pkg::NUM_AVG; n++)
        begin
            avg[n] = s3_avg_reg[n];
        end
    end

endmodule

>>> hw/rtl/ntec_emit.sv
// Result sequencer: walks the 1, 2, 4 or 8 extended points of a node into the
// output register, k outer, then j, i inner. Depends on ntec_pkg and the macros.
`include "node_to_extended_center_average_core_assert.svh"

module ntec_emit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sum_valid,
    output logic                  sum_take,
    input  ntec_pkg::value_t      avg [ntec_pkg::NUM_AVG],
    input  ntec_pkg::node_meta_t  sum_meta,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ntec_pkg::count_t      ext_i,
    output ntec_pkg::count_t      ext_j,
    output ntec_pkg::count_t      ext_k,
    output ntec_pkg::value_t      center_value,
    output logic                  last_of_run,
    output logic                  volume_done
);

    logic              isel_reg;
    logic              jsel_reg;
    logic              ksel_reg;
    logic              isel_next;
    logic              jsel_next;
    logic              ksel_next;

    logic              load_out;
    logic              run_end;
    logic              use_west;
    logic              use_north;
    logic              use_back;

    logic              out_valid_reg;
    ntec_pkg::count_t  ext_i_reg;
    ntec_pkg::count_t  ext_j_reg;
    ntec_pkg::count_t  ext_k_reg;
    ntec_pkg::value_t  center_value_reg;
    logic              last_of_run_reg;
    logic              volume_done_reg;

    assign load_out = sum_valid && (!out_valid_reg || out_ready);
    assign run_end  = (isel_reg == sum_meta.last_i) && (jsel_reg == sum_meta.last_j)
                   && (ksel_reg == sum_meta.last_k);
    assign sum_take = load_out && run_end;

    // The point on the node's own index draws on the lower node unless at zero
    assign use_west  = !isel_reg && (sum_meta.pos_i != '0);
    assign use_north = !jsel_reg && (sum_meta.pos_j != '0);
    assign use_back  = !ksel_reg && (sum_meta.pos_k != '0);

    // Step to the next extended point of this node, or back to the first at the run end
    always_comb
    begin
        isel_next = isel_reg;
        jsel_next = jsel_reg;
        ksel_next = ksel_reg;
        priority if (run_end)
        begin
            isel_next = 1'b0;
            jsel_next = 1'b0;
            ksel_next = 1'b0;
        end
        else if (sum_meta.last_i && !isel_reg)
        begin
            isel_next = 1'b1;
        end
        else if (sum_meta.last_j && !jsel_reg)
        begin
            isel_next = 1'b0;
            jsel_next = 1'b1;
        end
        else
        begin
            isel_next = 1'b0;
            jsel_next = 1'b0;
            ksel_next = 1'b1;
        end
    end

    // Sequencer and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            isel_reg      <= 1'b0;
            jsel_reg      <= 1'b0;
            ksel_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                isel_reg <= isel_next;
                jsel_reg <= jsel_next;
                ksel_reg <= ksel_next;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            ext_i_reg        <= ntec_pkg::CNT_W'(sum_meta.pos_i) + ntec_pkg::CNT_W'(isel_reg);
            ext_j_reg        <= ntec_pkg::CNT_W'(sum_meta.pos_j) + ntec_pkg::CNT_W'(jsel_reg);
            ext_k_reg        <= ntec_pkg::CNT_W'(sum_meta.pos_k) + ntec_pkg::CNT_W'(ksel_reg);
            center_value_reg <= avg[{use_back, use_north, use_west}];
            last_of_run_reg  <= run_end;
            volume_done_reg  <= run_end && sum_meta.last_i && sum_meta.last_j
                                && sum_meta.last_k;
        end
    end

    assign out_valid    = out_valid_reg;
    assign ext_i        = ext_i_reg;
    assign ext_j        = ext_j_reg;
    assign ext_k        = ext_k_reg;
    assign center_value = center_value_reg;
    assign last_of_run  = last_of_run_reg;
    assign volume_done  = volume_done_reg;

    `NTEC_ASSERT_IMPL(a_isel_only_on_last_i, clk, rst_n, sum_valid && isel_reg,
        sum_meta.last_i)
    `NTEC_ASSERT_IMPL(a_done_ends_run, clk, rst_n, out_valid_reg && volume_done_reg,
        last_of_run_reg)

endmodule
